// File: sv/arp_pkg.sv
// Shared types and constants for the adapter reply payload parser.
`default_nettype none

package arp_pkg;

  localparam int CHAR_W    = 8;
  localparam int HEX_W     = 7;
  localparam int CAP_W     = 11;
  localparam int PCOUNT_W  = 10;
  localparam int TOKEN_COUNT = 6;
  localparam int TOKEN_MAX   = 11;
  localparam int TOKEN_LEN_W = 4;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(1024);

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LF_HEX = 8'h66;

  localparam logic KIND_DIGIT  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_ERROR    = 2'd1,
    STATUS_OVERFLOW = 2'd2,
    STATUS_EMPTY    = 2'd3
  } status_t;

  // Byte 0 holds the last character of a token, byte k the one k places earlier.
  typedef logic [TOKEN_MAX-1:0][CHAR_W-1:0] token_t;

  localparam token_t TOKEN_TEXT [TOKEN_COUNT] = '{
    token_t'("NO DATA"),
    token_t'("STOPPED"),
    token_t'("ERROR"),
    token_t'("UNABLE"),
    token_t'("BUFFER FULL"),
    token_t'("?")
  };

  localparam logic [TOKEN_LEN_W-1:0] TOKEN_LEN [TOKEN_COUNT] = '{
    4'd7, 4'd7, 4'd5, 4'd6, 4'd11, 4'd1
  };

endpackage

`default_nettype wire

// File: sv/arp_if.sv
// Request and result channel interfaces of the reply payload parser.
`default_nettype none

interface arp_in_if;
  import arp_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;
  logic              end_of_reply;

  modport source (output valid, output char_in, output end_of_reply, input ready);
  modport sink   (input valid, input char_in, input end_of_reply, output ready);
endinterface

interface arp_out_if;
  import arp_pkg::*;
  logic                valid;
  logic                ready;
  logic                item_kind;
  logic [HEX_W-1:0]    hex_char;
  logic [1:0]          reply_status;
  logic [PCOUNT_W-1:0] payload_count;

  modport source (output valid, output item_kind, output hex_char, output reply_status,
                  output payload_count, input ready);
  modport sink   (input valid, input item_kind, input hex_char, input reply_status,
                  input payload_count, output ready);
endinterface

`default_nettype wire

// File: sv/arp_token_match.sv
// Compares the newest character and the recent history against the error tokens.
`default_nettype none

module arp_token_match (
  input  wire logic [arp_pkg::CHAR_W-1:0] char_in,
  input  wire logic [arp_pkg::CHAR_W-1:0] hist [arp_pkg::TOKEN_MAX-1],
  output logic                            hit
);
  import arp_pkg::*;

  logic [TOKEN_COUNT-1:0] tok_hit;

  always_comb begin
    for (int t = 0; t < TOKEN_COUNT; t++) begin
      tok_hit[t] = (TOKEN_TEXT[t][0] == char_in);
      for (int k = 1; k < TOKEN_MAX; k++) begin
        if (TOKEN_LEN_W'(k) < TOKEN_LEN[t] && TOKEN_TEXT[t][k] != hist[k-1]) begin
          tok_hit[t] = 1'b0;
        end
      end
    end
  end

  assign hit = |tok_hit;

endmodule

`default_nettype wire

// File: sv/adapter_reply_payload_parser.sv
// Top level of the adapter reply payload parser.
// Takes an adapter's text reply one character per request. Everything up to
// and including the first space (length prefix) is dropped; after that a colon
// opens a data section and CR or LF closes it. Hex digits inside a data section
// come out upper-cased as digit results (item_kind 0) with the running count,
// until payload_capacity - 1 digits have gone out; the next digit sets overflow
// and nothing more is emitted for that reply. A window of the latest characters
// watches the whole reply for "NO DATA", "STOPPED", "ERROR", "UNABLE",
// "BUFFER FULL" and "?". A request with end_of_reply set yields one status
// result (item_kind 1): error token, else overflow, else empty, else ok, and
// clears all reply state; the capacity register is kept. Capacity 0 acts as 1,
// capacity above MAX_CAPACITY saturates. Rate: one request per clock; the result is
// registered in the cycle after acceptance by the single result register; a stalled result
// register holds off the next request only while it is full and not taken.
`default_nettype none

module adapter_reply_payload_parser #(
  parameter int MAX_CAPACITY  = 1024,
  parameter int HISTORY_DEPTH = 10
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  arp_in_if.sink                        reply,
  arp_out_if.source                     result,
  input  wire logic                     cfg_write,
  input  wire logic [arp_pkg::CAP_W-1:0] cfg_data
);
  import arp_pkg::*;

  localparam int CNT_W = $clog2(MAX_CAPACITY);
  localparam int LIM_W = ($clog2(MAX_CAPACITY + 1) > CAP_W) ? $clog2(MAX_CAPACITY + 1) : CAP_W;

  // Configuration
  logic [CAP_W-1:0] payload_capacity;

  // Reply state
  logic              prefix_skipped, prefix_skipped_next;
  logic              in_data_section, in_data_section_next;
  logic [CNT_W-1:0]  digit_count, digit_count_next;
  logic              overflow_seen, overflow_seen_next;
  logic              error_token_seen, error_token_seen_next;
  logic [CHAR_W-1:0] char_history [HISTORY_DEPTH];

  // Per-request decode
  logic              accept;
  logic              token_hit;
  logic              is_hex;
  logic              emit_digit;
  logic              at_limit;
  logic [LIM_W-1:0]  cap_eff;
  logic [LIM_W-1:0]  allowed;
  status_t           status;
  logic [CHAR_W-1:0] c;

  assign c      = reply.char_in;
  assign accept = reply.valid && reply.ready;

  // Output register frees up when empty or being drained this cycle
  assign reply.ready = !result.valid || result.ready;

  // Effective digit allowance: capacity clamped to [1, MAX_CAPACITY], minus one
  always_comb begin
    cap_eff = LIM_W'(payload_capacity);
    if (cap_eff == '0) begin
      cap_eff = LIM_W'(1);
    end else if (cap_eff > LIM_W'(MAX_CAPACITY)) begin
      cap_eff = LIM_W'(MAX_CAPACITY);
    end
    allowed = cap_eff - LIM_W'(1);
  end

  arp_token_match u_match (
    .char_in (c),
    .hist    (char_history[0:TOKEN_MAX-2]),
    .hit     (token_hit)
  );

  assign is_hex = (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UF) ||
                  (c >= CH_LA && c <= CH_LF_HEX);
  assign at_limit = LIM_W'(digit_count) >= allowed;

  // Parser next state for a character request
  always_comb begin
    prefix_skipped_next   = prefix_skipped;
    in_data_section_next  = in_data_section;
    digit_count_next      = digit_count;
    overflow_seen_next    = overflow_seen;
    error_token_seen_next = error_token_seen || token_hit;
    emit_digit            = 1'b0;
    if (!overflow_seen) begin
      if (!prefix_skipped) begin
        if (c == CH_SPACE) begin
          prefix_skipped_next = 1'b1;
        end
      end else if (c == CH_COLON) begin
        in_data_section_next = 1'b1;
      end else if (c == CH_CR || c == CH_LF) begin
        in_data_section_next = 1'b0;
      end else if (in_data_section && is_hex) begin
        if (at_limit) begin
          overflow_seen_next = 1'b1;
        end else begin
          digit_count_next = digit_count + CNT_W'(1);
          emit_digit       = 1'b1;
        end
      end
    end
  end

  // Final status priority: error, overflow, empty, ok
  always_comb begin
    if (error_token_seen) begin
      status = STATUS_ERROR;
    end else if (overflow_seen) begin
      status = STATUS_OVERFLOW;
    end else if (digit_count == '0) begin
      status = STATUS_EMPTY;
    end else begin
      status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_capacity <= CAPACITY_RESET;
    end else if (cfg_write) begin
      payload_capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_skipped   <= 1'b0;
      in_data_section  <= 1'b0;
      digit_count      <= '0;
      overflow_seen    <= 1'b0;
      error_token_seen <= 1'b0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        char_history[i] <= '0;
      end
    end else if (accept) begin
      if (reply.end_of_reply) begin
        prefix_skipped   <= 1'b0;
        in_data_section  <= 1'b0;
        digit_count      <= '0;
        overflow_seen    <= 1'b0;
        error_token_seen <= 1'b0;
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
          char_history[i] <= '0;
        end
      end else begin
        prefix_skipped   <= prefix_skipped_next;
        in_data_section  <= in_data_section_next;
        digit_count      <= digit_count_next;
        overflow_seen    <= overflow_seen_next;
        error_token_seen <= error_token_seen_next;
        char_history[0]  <= c;
        for (int i = 1; i < HISTORY_DEPTH; i++) begin
          char_history[i] <= char_history[i-1];
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (accept) begin
      result.valid <= reply.end_of_reply || emit_digit;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (reply.end_of_reply) begin
        result.item_kind     <= KIND_STATUS;
        result.hex_char      <= '0;
        result.reply_status  <= status;
        result.payload_count <= PCOUNT_W'(digit_count);
      end else begin
        result.item_kind     <= KIND_DIGIT;
        // Fold lower case by clearing the case bit of letters
        result.hex_char      <= (c >= CH_LA) ? (c[HEX_W-1:0] & ~7'h20) : c[HEX_W-1:0];
        result.reply_status  <= STATUS_OK;
        result.payload_count <= PCOUNT_W'(digit_count_next);
      end
    end
  end

  // A digit only goes out while under the allowance
  a_digit_in_allowance: assert property (@(posedge clk) disable iff (rst)
    (accept && emit_digit) |-> (LIM_W'(digit_count) < allowed))
    else $error("digit emitted past the capacity allowance");

  // Overflow sticks until the end of the reply
  a_overflow_sticky: assert property (@(posedge clk) disable iff (rst)
    (overflow_seen && !(accept && reply.end_of_reply)) |=> overflow_seen)
    else $error("overflow flag dropped inside a reply");

  // End of reply leaves the parser cleared and a status result pending
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && reply.end_of_reply) |=>
      (digit_count == '0 && !prefix_skipped && !error_token_seen && !overflow_seen &&
       result.valid && result.item_kind == KIND_STATUS))
    else $error("end of reply did not clear state or post status");

endmodule

`default_nettype wire
